// ===== rtl/acf_pkg.sv =====
package acf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int ECHO_LEN  = FRAME_LEN + 1;

    localparam logic [2:0] K_ECHO    = 3'd0;
    localparam logic [2:0] K_HIGH1   = 3'd1;
    localparam logic [2:0] K_HIGH2   = 3'd2;
    localparam logic [2:0] K_LOW1    = 3'd3;
    localparam logic [2:0] K_LOW2    = 3'd4;
    localparam logic [2:0] K_TIMER   = 3'd5;
    localparam logic [2:0] K_LANG    = 3'd6;
    localparam logic [2:0] K_REFRESH = 3'd7;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam logic [9:0] MS_PER_S   = 10'd1000;

    // alarm value starts at byte 4, timer value at byte 2
    localparam logic [3:0] ALARM_POS  = 4'd4;
    localparam logic [3:0] TIMER_POS  = 4'd2;
    localparam logic [3:0] IDX_NL     = 4'd8;
    localparam logic [3:0] IDX_SET    = 4'd9;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [3:0] idx;
        logic [7:0] head;
    } acf_ctl_t;

endpackage

// ===== rtl/acf_cell.sv =====
module acf_cell
    import acf_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] load_d,
    input  logic       shift,
    input  logic [7:0] shift_d,
    output logic [7:0] q
);

    logic [7:0] q_reg;
    logic [7:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (load)
        begin
            q_next = load_d;
        end
        else if (shift)
        begin
            q_next = shift_d;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/acf_setting.sv =====
module acf_setting
    import acf_pkg::*;
(
    input  logic        clk,
    input  acf_ctl_t    ctl,
    input  logic [7:0]  cmd,
    input  logic [7:0]  grp,
    input  logic [7:0]  sel,
    input  logic [7:0]  lang,
    input  logic [31:0] now_ms,
    output logic [2:0]  kind,
    output logic [31:0] value
);

    logic [7:0]  cmd_reg, grp_reg, sel_reg, lang_reg;
    logic [31:0] now_reg;
    logic [19:0] acc_reg, acc_next;
    logic        ok_reg, ok_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] val_reg, val_next;
    logic        in_range;
    logic        is_digit;
    logic [3:0]  digit;
    logic [29:0] prod;

    always_comb
    begin
        in_range = 1'b0;
        case (cmd_reg)
            CH_A:    in_range = (ctl.idx >= ALARM_POS) && (ctl.idx < IDX_NL);
            CH_T:    in_range = (ctl.idx >= TIMER_POS) && (ctl.idx < IDX_NL);
            default: in_range = 1'b0;
        endcase
    end

    assign is_digit = ctl.head inside {[CH_ZERO:CH_NINE]};
    assign digit    = 4'(ctl.head - CH_ZERO);
    assign prod     = 30'(acc_reg) * 30'(MS_PER_S);

    always_comb
    begin
        acc_next  = acc_reg;
        ok_next   = ok_reg;
        kind_next = kind_reg;
        val_next  = val_reg;
        if (ctl.load)
        begin
            acc_next = '0;
            ok_next  = 1'b1;
        end
        else if (ctl.step && in_range)
        begin
            ok_next  = ok_reg && is_digit;
            acc_next = {acc_reg[16:0], 3'b000} + {acc_reg[18:0], 1'b0} + 20'(digit);
        end
        else if (ctl.step && (ctl.idx == IDX_NL))
        begin
            kind_next = K_REFRESH;
            val_next  = '0;
            case (cmd_reg)
                CH_A:
                begin
                    if (ok_reg)
                    begin
                        if (grp_reg == CH_H && sel_reg == CH_ONE)
                        begin
                            kind_next = K_HIGH1;
                        end
                        else if (grp_reg == CH_H && sel_reg == CH_TWO)
                        begin
                            kind_next = K_HIGH2;
                        end
                        else if (grp_reg == CH_L && sel_reg == CH_ONE)
                        begin
                            kind_next = K_LOW1;
                        end
                        else if (grp_reg == CH_L && sel_reg == CH_TWO)
                        begin
                            kind_next = K_LOW2;
                        end
                        if (kind_next != K_REFRESH)
                        begin
                            val_next = 32'(acc_reg);
                        end
                    end
                end
                CH_T:
                begin
                    if (ok_reg)
                    begin
                        kind_next = K_TIMER;
                        val_next  = {2'b00, prod} + now_reg;
                    end
                end
                CH_L:
                begin
                    if (lang_reg == CH_P)
                    begin
                        kind_next = K_LANG;
                    end
                    else if (lang_reg == CH_E)
                    begin
                        kind_next = K_LANG;
                        val_next  = 32'd1;
                    end
                end
                default:
                begin
                    kind_next = K_REFRESH;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            grp_reg  <= grp;
            sel_reg  <= sel;
            lang_reg <= lang;
            now_reg  <= now_ms;
        end
        acc_reg  <= acc_next;
        ok_reg   <= ok_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
    end

    assign kind  = kind_reg;
    assign value = val_reg;

endmodule

// ===== rtl/ascii_command_frame_parser_top.sv =====
// A frame's first echo request is offered in the cycle after its closing byte is taken.
// Throughput: one byte per cycle; a frame drains as ten output requests, one per cycle
// at best, paced by the echo cell chain; a closing byte waits while a frame drains
// and is taken in the same cycle as the frame's last request.
// The timer deadline multiply runs as the newline is taken.
// Reset (rst_n, async, active low) clears the burst count, the busy flag and the output counter.
module ascii_command_frame_parser_top
    import acf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        burst_end,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  echo_char,
    output logic [31:0] setting_value,
    output logic        last
);

    logic [3:0] count_reg, count_next;
    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic       in_acc, out_acc;
    logic       store_shift;
    logic       frame_ok;
    logic [7:0] store_q [FRAME_LEN];
    logic [7:0] echo_q [ECHO_LEN];
    logic [7:0] frame_byte [FRAME_LEN];
    acf_ctl_t   ctl;
    logic [2:0] set_kind;
    logic [31:0] set_value;

    // a closing byte may reload the chains as the last request leaves
    assign in_ready    = !busy_reg || !burst_end || (out_acc && last);
    assign in_acc      = in_valid && in_ready;
    assign out_valid   = busy_reg;
    assign out_acc     = out_valid && out_ready;
    assign store_shift = in_acc && (count_reg < 4'(FRAME_LEN));

    // store chain shifts toward cell 0; with seven bytes held, byte 0 sits in cell 1
    genvar g;
    generate
        for (g = 0; g < FRAME_LEN; g++)
        begin : g_store
            acf_cell u_cell (
                .clk     (clk),
                .load    (1'b0),
                .load_d  (8'h00),
                .shift   (store_shift),
                .shift_d ((g == FRAME_LEN - 1) ? rx_byte : store_q[(g + 1) % FRAME_LEN]),
                .q       (store_q[g])
            );
        end
        for (g = 0; g < FRAME_LEN; g++)
        begin : g_frame
            if (g == FRAME_LEN - 1)
            begin : g_tail
                assign frame_byte[g] = rx_byte;
            end
            else
            begin : g_body
                assign frame_byte[g] = store_q[g + 1];
            end
        end
    endgenerate

    assign frame_ok = in_acc && burst_end && (count_reg == 4'(FRAME_LEN - 1))
                      && (frame_byte[0] == CH_DOLLAR);

    generate
        for (g = 0; g < ECHO_LEN; g++)
        begin : g_echo
            acf_cell u_cell (
                .clk     (clk),
                .load    (frame_ok),
                .load_d  ((g == ECHO_LEN - 1) ? CH_NEWLINE : frame_byte[g % FRAME_LEN]),
                .shift   (out_acc),
                .shift_d ((g == ECHO_LEN - 1) ? 8'h00 : echo_q[(g + 1) % ECHO_LEN]),
                .q       (echo_q[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        if (in_acc)
        begin
            if (burst_end)
            begin
                count_next = '0;
            end
            else if (count_reg <= 4'(FRAME_LEN))
            begin
                count_next = count_reg + 4'd1;
            end
        end
        if (out_acc)
        begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg == IDX_SET)
            begin
                busy_next = 1'b0;
            end
        end
        if (frame_ok)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    assign ctl.load = frame_ok;
    assign ctl.step = out_acc;
    assign ctl.idx  = idx_reg;
    assign ctl.head = echo_q[0];

    acf_setting u_setting (
        .clk    (clk),
        .ctl    (ctl),
        .cmd    (frame_byte[1]),
        .grp    (frame_byte[2]),
        .sel    (frame_byte[3]),
        .lang   (frame_byte[7]),
        .now_ms (now_ms),
        .kind   (set_kind),
        .value  (set_value)
    );

    assign last          = (idx_reg == IDX_SET);
    assign kind          = last ? set_kind : K_ECHO;
    assign echo_char     = last ? 8'h00 : echo_q[0];
    assign setting_value = last ? set_value : 32'd0;

endmodule

// ===== test/ascii_command_frame_parser_top_tb.sv =====
module ascii_command_frame_parser_top_tb;
    import acf_pkg::*;

    localparam int N_ITEMS         = 220;
    localparam int N_DIRECTED      = 21;
    localparam int MAX_WAIT        = 11;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_TAIL      = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [31:0] value;
        logic        last;
    } reply_t;

    typedef enum {ROW_PREDICT, ROW_SETTING, ROW_DROP} row_check_t;

    typedef struct {
        string       text;
        logic [31:0] now;
        row_check_t  check;
        logic [2:0]  kind;
        logic [31:0] value;
    } burst_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        burst_end;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  echo_char;
    logic [31:0] setting_value;
    logic        last;

    // parser state mirrored by the predictor
    logic [7:0]  stored_bytes [8];
    logic [3:0]  byte_count;

    reply_t      reply_q [$];
    int          mismatches;
    int          items_sent;
    int          idle_cycles;
    bit          tx_calm;
    bit          hold_pending;

    // directed bursts; typed setting results where the answer is obvious
    burst_row_t directed_rows [N_DIRECTED] = '{
        '{"$AH10000", 32'd0,          ROW_SETTING, K_HIGH1,   32'd0},
        '{"$AH29999", 32'hFFFF_FFFF,  ROW_SETTING, K_HIGH2,   32'd9999},
        '{"$AL10123", 32'd7,          ROW_PREDICT, K_REFRESH, 32'd0},
        '{"$AL24507", 32'd0,          ROW_PREDICT, K_REFRESH, 32'd0},
        '{"$AX11234", 32'd0,          ROW_SETTING, K_REFRESH, 32'd0},
        '{"$AH31234", 32'd0,          ROW_SETTING, K_REFRESH, 32'd0},
        '{"$AL1/:90", 32'd0,          ROW_SETTING, K_REFRESH, 32'd0},
        '{"$T000000", 32'd0,          ROW_SETTING, K_TIMER,   32'd0},
        '{"$T999999", 32'hFFFF_FFFF,  ROW_SETTING, K_TIMER,   32'd999998999},
        '{"$T004321", 32'd123456789,  ROW_PREDICT, K_REFRESH, 32'd0},
        '{"$T12a456", 32'd5,          ROW_SETTING, K_REFRESH, 32'd0},
        '{"$LANG::P", 32'd0,          ROW_SETTING, K_LANG,    32'd0},
        '{"$LANG::E", 32'd0,          ROW_SETTING, K_LANG,    32'd1},
        '{"$LANG::p", 32'd0,          ROW_SETTING, K_REFRESH, 32'd0},
        '{"$Z123456", 32'd0,          ROW_SETTING, K_REFRESH, 32'd0},
        '{"#AH10000", 32'd0,          ROW_DROP,    K_REFRESH, 32'd0},
        '{"$AH1000",  32'd0,          ROW_DROP,    K_REFRESH, 32'd0},
        '{"$AH100000", 32'd0,         ROW_DROP,    K_REFRESH, 32'd0},
        '{"$AH1000099999999\377", 32'd0, ROW_DROP, K_REFRESH, 32'd0},
        '{"$",        32'd0,          ROW_DROP,    K_REFRESH, 32'd0},
        '{"$LANG::E", 32'd0,          ROW_PREDICT, K_REFRESH, 32'd0}
    };

    ascii_command_frame_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .burst_end     (burst_end),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .echo_char     (echo_char),
        .setting_value (setting_value),
        .last          (last)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic digit_run(input int pos, input int cnt, output logic [31:0] val);
        logic [7:0] c;
        int         i;
        val = 32'd0;
        for (i = 0; i < cnt; i++)
        begin
            c = stored_bytes[pos + i];
            if (c < CH_ZERO || c > CH_NINE)
                return 1'b0;
            val = val * 32'd10 + 32'(c - CH_ZERO);
        end
        return 1'b1;
    endfunction

    // queues the replies one accepted byte causes; returns how many
    function automatic int parse_byte(input logic [7:0] b, input logic fin,
                                      input logic [31:0] now);
        logic [2:0]  k;
        logic [31:0] v;
        logic [31:0] val;
        int          i;
        k   = K_REFRESH;
        val = 32'd0;
        if (byte_count < 4'(FRAME_LEN))
            stored_bytes[byte_count[2:0]] = b;
        if (byte_count < 4'(FRAME_LEN + 1))
            byte_count = byte_count + 4'd1;
        if (!fin)
            return 0;
        if (byte_count != 4'(FRAME_LEN) || stored_bytes[0] != CH_DOLLAR)
        begin
            byte_count = 4'd0;
            return 0;
        end
        byte_count = 4'd0;
        for (i = 0; i < FRAME_LEN; i++)
            reply_q.push_back(reply_t'{K_ECHO, stored_bytes[i], 32'd0, 1'b0});
        reply_q.push_back(reply_t'{K_ECHO, CH_NEWLINE, 32'd0, 1'b0});
        case (stored_bytes[1])
            CH_A:
            begin
                if (digit_run(int'(ALARM_POS), 4, v))
                begin
                    if (stored_bytes[2] == CH_H && stored_bytes[3] == CH_ONE)
                        k = K_HIGH1;
                    else if (stored_bytes[2] == CH_H && stored_bytes[3] == CH_TWO)
                        k = K_HIGH2;
                    else if (stored_bytes[2] == CH_L && stored_bytes[3] == CH_ONE)
                        k = K_LOW1;
                    else if (stored_bytes[2] == CH_L && stored_bytes[3] == CH_TWO)
                        k = K_LOW2;
                    if (k != K_REFRESH)
                        val = v;
                end
            end
            CH_T:
            begin
                if (digit_run(int'(TIMER_POS), 6, v))
                begin
                    k   = K_TIMER;
                    val = v * 32'(MS_PER_S) + now;
                end
            end
            CH_L:
            begin
                if (stored_bytes[7] == CH_P)
                begin
                    k   = K_LANG;
                    val = 32'd0;
                end
                else if (stored_bytes[7] == CH_E)
                begin
                    k   = K_LANG;
                    val = 32'd1;
                end
            end
            default:
            begin
            end
        endcase
        reply_q.push_back(reply_t'{k, 8'd0, val, 1'b1});
        return ECHO_LEN + 1;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic [31:0] now,
                             output int n);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        burst_end <= fin;
        now_ms    <= now;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        n = parse_byte(b, fin, now);
    endtask

    task automatic send_random_burst();
        logic [7:0]  frame [$];
        logic [31:0] now;
        int          shape;
        int          i;
        int          n;
        shape = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0)
            tx_calm = !tx_calm;
        if (shape < 7)
        begin
            // well-formed frame with random content, sometimes damaged
            frame.push_back(CH_DOLLAR);
            case ($urandom_range(0, 3))
                0:
                begin
                    frame.push_back(CH_A);
                    frame.push_back($urandom_range(0, 4) == 0 ? rand_byte() :
                                    ($urandom_range(0, 1) ? CH_H : CH_L));
                    frame.push_back($urandom_range(0, 4) == 0 ? rand_byte() :
                                    ($urandom_range(0, 1) ? CH_ONE : CH_TWO));
                    repeat (4) frame.push_back(rand_digit());
                end
                1:
                begin
                    frame.push_back(CH_T);
                    repeat (6) frame.push_back(rand_digit());
                end
                2:
                begin
                    frame.push_back(CH_L);
                    repeat (5) frame.push_back(rand_byte());
                    frame.push_back($urandom_range(0, 4) == 0 ? rand_byte() :
                                    ($urandom_range(0, 1) ? CH_P : CH_E));
                end
                default:
                begin
                    repeat (7) frame.push_back(rand_byte());
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                frame[$urandom_range(2, 7)] = rand_byte();
            if (shape == 6)
            begin
                if ($urandom_range(0, 1))
                    void'(frame.pop_back());
                else
                    frame.push_back(rand_byte());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 12)) frame.push_back(rand_byte());
            if ($urandom_range(0, 1))
                frame[0] = CH_DOLLAR;
        end
        for (i = 0; i < frame.size(); i++)
        begin
            case ($urandom_range(0, 5))
                0:       now = 32'd0;
                1:       now = 32'hFFFF_FFFF;
                default: now = $urandom;
            endcase
            send_byte(frame[i], i == frame.size() - 1, now, n);
        end
    endtask

    task automatic wait_drained();
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        string text;
        int    i;
        int    n;
        bit    pressure_done;
        bit    pause_done;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'd0;
        burst_end     = 1'b0;
        now_ms        = 32'd0;
        byte_count    = 4'd0;
        mismatches    = 0;
        items_sent    = 0;
        tx_calm       = 1'b0;
        hold_pending  = 1'b0;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        for (i = 0; i < FRAME_LEN; i++)
            stored_bytes[i] = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            text = directed_rows[r].text;
            for (i = 0; i < text.len(); i++)
                send_byte(text[i], i == text.len() - 1, directed_rows[r].now, n);
            if (directed_rows[r].check != ROW_PREDICT)
            begin
                repeat (n) void'(reply_q.pop_back());
                if (directed_rows[r].check == ROW_SETTING)
                begin
                    for (i = 0; i < FRAME_LEN; i++)
                        reply_q.push_back(reply_t'{K_ECHO, text[i], 32'd0, 1'b0});
                    reply_q.push_back(reply_t'{K_ECHO, CH_NEWLINE, 32'd0, 1'b0});
                    reply_q.push_back(reply_t'{directed_rows[r].kind, 8'd0,
                                               directed_rows[r].value, 1'b1});
                end
            end
        end
        wait_drained();

        while (items_sent < N_ITEMS)
        begin
            if (!pressure_done && items_sent > 90)
            begin
                // receiver holds off while back-to-back frames pile up
                hold_pending = 1'b1;
                tx_calm      = 1'b1;
                repeat (5) send_random_burst();
                pressure_done = 1'b1;
            end
            else if (!pause_done && items_sent > 160)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            else
                send_random_burst();
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("ascii_command_frame_parser_top regression: pass");
        else
            $display("ascii_command_frame_parser_top regression: fail");
        $finish;
    end

    initial
    begin : receiver
        int stall;
        bit rx_calm;
        rx_calm   = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
                stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 19) == 0)
                rx_calm = !rx_calm;
        end
    end

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                $error("request with none expected: kind %0d echo_char %0h value %0h last %0b",
                       kind, echo_char, setting_value, last);
                mismatches++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    mismatches++;
                end
                if (echo_char !== want.ch)
                begin
                    $error("echo_char: expected %0h, got %0h", want.ch, echo_char);
                    mismatches++;
                end
                if (setting_value !== want.value)
                begin
                    $error("setting_value: expected %0h, got %0h", want.value, setting_value);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("ascii_command_frame_parser_top regression: fail");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/acf_pkg.sv
rtl/acf_cell.sv
rtl/acf_setting.sv
rtl/ascii_command_frame_parser_top.sv
test/ascii_command_frame_parser_top_tb.sv
